>>> sv/ppdd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the position loop with deadzone and dither.
// No dependencies.
package ppdd_pkg;

    localparam int COUNT_WIDTH = 32;

    localparam int GAIN_W = 24;
    localparam int PWM_W  = 15;
    localparam int TICK_W = 16;
    localparam int STEP_W = 16;
    localparam int REF_W  = 17;
    localparam int VEL_W  = 16;
    localparam int DRV_W  = 16;
    localparam int DIR_W  = 2;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 24;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BWD  = 2'd2;

    localparam logic [2:0] PHASE_FIRST = 3'd0;
    localparam logic [2:0] PHASE_POS   = 3'd1;
    localparam logic [2:0] PHASE_NEG   = 3'd3;
    localparam logic [2:0] PHASE_LAST  = 3'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_Q16        = 4'd0,
        REG_DEADZONE_FWD    = 4'd1,
        REG_DEADZONE_BWD    = 4'd2,
        REG_DITHER_AMPL     = 4'd3,
        REG_MAX_PWM         = 4'd4,
        REG_STEP_TICKS      = 4'd5,
        REG_STEP_COUNTS     = 4'd6,
        REG_DEADBAND_COUNTS = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_q16;
        logic [PWM_W-1:0]  deadzone_fwd;
        logic [PWM_W-1:0]  deadzone_bwd;
        logic [PWM_W-1:0]  dither_amplitude;
        logic [PWM_W-1:0]  max_pwm;
        logic [TICK_W-1:0] step_ticks;
        logic [STEP_W-1:0] step_counts;
        logic [STEP_W-1:0] deadband_counts;
    } cfg_t;

endpackage

>>> sv/ppdd_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the position loop.
// Depends on ppdd_pkg.
module ppdd_cfg_regs
    import ppdd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_q16         <= GAIN_W'(132458);
            cfg_reg.deadzone_fwd     <= PWM_W'(1500);
            cfg_reg.deadzone_bwd     <= PWM_W'(1500);
            cfg_reg.dither_amplitude <= PWM_W'(467);
            cfg_reg.max_pwm          <= PWM_W'(5000);
            cfg_reg.step_ticks       <= TICK_W'(1000);
            cfg_reg.step_counts      <= STEP_W'(1319);
            cfg_reg.deadband_counts  <= STEP_W'(2);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GAIN_Q16:        cfg_reg.gain_q16         <= cfg_data[GAIN_W-1:0];
                REG_DEADZONE_FWD:    cfg_reg.deadzone_fwd     <= cfg_data[PWM_W-1:0];
                REG_DEADZONE_BWD:    cfg_reg.deadzone_bwd     <= cfg_data[PWM_W-1:0];
                REG_DITHER_AMPL:     cfg_reg.dither_amplitude <= cfg_data[PWM_W-1:0];
                REG_MAX_PWM:         cfg_reg.max_pwm          <= cfg_data[PWM_W-1:0];
                REG_STEP_TICKS:      cfg_reg.step_ticks       <= cfg_data[TICK_W-1:0];
                REG_STEP_COUNTS:     cfg_reg.step_counts      <= cfg_data[STEP_W-1:0];
                REG_DEADBAND_COUNTS: cfg_reg.deadband_counts  <= cfg_data[STEP_W-1:0];
                default:             ;
            endcase
        end
    end

endmodule

>>> sv/p_position_loop_deadzone_dither_unit.sv
`timescale 1ns / 1ps
// Proportional position loop with deadzone compensation and square dither.
// Four-stage pipeline (capture, error/velocity, multiply/saturate, deadzone/dither);
// one request per cycle, each stage stalls only when the one after it is full.
// Reset clears the sequencer, previous count, dither flag and all stage valids;
// configuration returns to its default values. Depends on ppdd_pkg, ppdd_cfg_regs.
module p_position_loop_deadzone_dither_unit
    import ppdd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [31:0]       encoder_count,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [PWM_W-1:0]         pwm_duty,
    output logic [DIR_W-1:0]         direction,
    output logic signed [REF_W-1:0]  reference_counts,
    output logic signed [VEL_W-1:0]  velocity_counts,
    output logic signed [DRV_W-1:0]  ideal_drive,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW    = COUNT_WIDTH;
    localparam int ERR_W = ((CW > REF_W) ? CW : REF_W) + 1;
    localparam int MUL_W = (ERR_W > 32) ? 32 : ERR_W;
    localparam int SHR_W = MUL_W + GAIN_W - 16;
    localparam int FIN_W = 18;

    cfg_t cfg;

    ppdd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    function automatic logic signed [FIN_W-1:0] clamp_sym(
        input logic signed [FIN_W-1:0] v,
        input logic [PWM_W-1:0]        lim
    );
        logic signed [FIN_W-1:0] hi;
        logic signed [FIN_W-1:0] lo;
        hi = $signed(FIN_W'(lim));
        lo = -hi;
        if (v > hi)
            clamp_sym = hi;
        else if (v < lo)
            clamp_sym = lo;
        else
            clamp_sym = v;
    endfunction

    // Handshake across stages
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic in_fire;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign in_fire  = in_valid && in_ready;

    // Stage 1: sequencer and capture
    logic [TICK_W-1:0]       tick_reg, tick_inc, tick_next;
    logic [2:0]              phase_reg, phase_next;
    logic signed [CW-1:0]    prev_reg;
    logic signed [CW-1:0]    count_in;
    logic signed [REF_W-1:0] ref_next;

    logic signed [CW-1:0]    s1_count_reg, s1_prev_reg;
    logic signed [REF_W-1:0] s1_ref_reg;

    assign count_in = encoder_count[CW-1:0];
    assign tick_inc = tick_reg + 1'b1;

    always_comb
    begin
        tick_next  = tick_inc;
        phase_next = phase_reg;
        if (tick_inc >= cfg.step_ticks)
        begin
            tick_next  = '0;
            phase_next = (phase_reg >= PHASE_LAST) ? PHASE_FIRST : phase_reg + 3'd1;
        end
        priority if (phase_next == PHASE_POS)
            ref_next = $signed({1'b0, cfg.step_counts});
        else if (phase_next == PHASE_NEG)
            ref_next = -$signed({1'b0, cfg.step_counts});
        else
            ref_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= '0;
            phase_reg <= '0;
            prev_reg  <= '0;
        end
        else if (in_fire)
        begin
            tick_reg  <= tick_next;
            phase_reg <= phase_next;
            prev_reg  <= count_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_count_reg <= count_in;
            s1_prev_reg  <= prev_reg;
            s1_ref_reg   <= ref_next;
        end
    end

    // Stage 2: velocity, error magnitude, deadband
    logic signed [CW:0]      diff;
    logic signed [VEL_W-1:0] vel_next;
    logic signed [ERR_W-1:0] err;
    logic [ERR_W-1:0]        err_mag;
    logic [MUL_W-1:0]        mag_next;
    logic                    band_next;

    logic signed [VEL_W-1:0] s2_vel_reg;
    logic signed [REF_W-1:0] s2_ref_reg;
    logic [MUL_W-1:0]        s2_mag_reg;
    logic                    s2_neg_reg, s2_band_reg;

    assign diff = (CW+1)'(s1_count_reg) - (CW+1)'(s1_prev_reg);

    always_comb
    begin
        if (diff > (CW+1)'(32767))
            vel_next = VEL_W'(32767);
        else if (diff < -(CW+1)'(32767))
            vel_next = VEL_W'(-32768);
        else
            vel_next = diff[VEL_W-1:0];
        err       = ERR_W'(s1_ref_reg) - ERR_W'(s1_count_reg);
        err_mag   = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        // Above the multiplier width the product saturates whenever gain is nonzero.
        mag_next  = (err_mag > ERR_W'({MUL_W{1'b1}})) ? {MUL_W{1'b1}} : err_mag[MUL_W-1:0];
        band_next = err_mag < ERR_W'(cfg.deadband_counts);
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            s2_vel_reg  <= vel_next;
            s2_ref_reg  <= s1_ref_reg;
            s2_mag_reg  <= mag_next;
            s2_neg_reg  <= err[ERR_W-1];
            s2_band_reg <= band_next;
        end
    end

    // Stage 3: gain multiply and saturation
    logic [MUL_W+GAIN_W-1:0] prod;
    logic [SHR_W-1:0]        prod_shr;
    logic [PWM_W-1:0]        drv_mag;
    logic signed [DRV_W-1:0] drive_next;

    logic signed [VEL_W-1:0] s3_vel_reg;
    logic signed [REF_W-1:0] s3_ref_reg;
    logic signed [DRV_W-1:0] s3_drive_reg;

    always_comb
    begin
        prod     = (MUL_W+GAIN_W)'(s2_mag_reg) * (MUL_W+GAIN_W)'(cfg.gain_q16);
        prod_shr = prod[MUL_W+GAIN_W-1:16];
        if (s2_band_reg)
            drv_mag = '0;
        else if (prod_shr > SHR_W'(cfg.max_pwm))
            drv_mag = cfg.max_pwm;
        else
            drv_mag = prod_shr[PWM_W-1:0];
        drive_next = s2_neg_reg ? -$signed({1'b0, drv_mag}) : $signed({1'b0, drv_mag});
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            s3_vel_reg   <= s2_vel_reg;
            s3_ref_reg   <= s2_ref_reg;
            s3_drive_reg <= drive_next;
        end
    end

    // Stage 4: deadzone, dither, direction
    logic                    dither_reg, dither_next;
    logic signed [FIN_W-1:0] drv_ext, dz, fin;
    logic [FIN_W-1:0]        fin_mag;
    logic                    s4_load;

    logic [PWM_W-1:0]        pwm_reg;
    logic [DIR_W-1:0]        dir_reg;
    logic signed [REF_W-1:0] ref_out_reg;
    logic signed [VEL_W-1:0] vel_out_reg;
    logic signed [DRV_W-1:0] drv_out_reg;

    assign s4_load = rdy4 && v3_reg;

    always_comb
    begin
        drv_ext     = FIN_W'(s3_drive_reg);
        dither_next = dither_reg;
        fin         = drv_ext;
        if (s3_drive_reg > 0)
            dz = clamp_sym(drv_ext + $signed(FIN_W'(cfg.deadzone_fwd)), cfg.max_pwm);
        else
            dz = clamp_sym(drv_ext - $signed(FIN_W'(cfg.deadzone_bwd)), cfg.max_pwm);
        if (s3_drive_reg != 0)
        begin
            dither_next = !dither_reg;
            if (dither_next)
                fin = clamp_sym(dz + $signed(FIN_W'(cfg.dither_amplitude)), cfg.max_pwm);
            else
                fin = clamp_sym(dz - $signed(FIN_W'(cfg.dither_amplitude)), cfg.max_pwm);
        end
        fin_mag = fin[FIN_W-1] ? FIN_W'(-fin) : FIN_W'(fin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dither_reg <= 1'b0;
        else if (s4_load)
            dither_reg <= dither_next;
    end

    always_ff @(posedge clk)
    begin
        if (s4_load)
        begin
            pwm_reg     <= fin_mag[PWM_W-1:0];
            ref_out_reg <= s3_ref_reg;
            vel_out_reg <= s3_vel_reg;
            drv_out_reg <= s3_drive_reg;
            if (fin > 0)
                dir_reg <= DIR_FWD;
            else if (fin < 0)
                dir_reg <= DIR_BWD;
            else
                dir_reg <= DIR_STOP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    assign out_valid        = v4_reg;
    assign pwm_duty         = pwm_reg;
    assign direction        = dir_reg;
    assign reference_counts = ref_out_reg;
    assign velocity_counts  = vel_out_reg;
    assign ideal_drive      = drv_out_reg;

endmodule

>>> bench/p_position_loop_deadzone_dither_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for p_position_loop_deadzone_dither_unit: a bit-exact predictor of the
// position loop checks every response in order across register settings and idle patterns.
// Depends on ppdd_pkg and p_position_loop_deadzone_dither_unit.
module p_position_loop_deadzone_dither_unit_test;
    import ppdd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 4'd12;

    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 230;

    localparam cfg_t CFG_AT_RESET = '{
        gain_q16:         24'd132458,
        deadzone_fwd:     15'd1500,
        deadzone_bwd:     15'd1500,
        dither_amplitude: 15'd467,
        max_pwm:          15'd5000,
        step_ticks:       16'd1000,
        step_counts:      16'd1319,
        deadband_counts:  16'd2
    };

    // deadband edge, saturation, velocity limits both ways, count extremes
    localparam logic signed [31:0] EDGE_COUNTS [15] = '{
        32'sd0, 32'sd1, -32'sd2, 32'sd2, 32'sd3000, -32'sd3000, 32'sd1319, -32'sd1319,
        32'sd32767, 32'sd0, -32'sd32768, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'sd0
    };

    typedef struct packed {
        logic [PWM_W-1:0] duty;
        logic [DIR_W-1:0] dir;
        logic [REF_W-1:0] setpoint;
        logic [VEL_W-1:0] velocity;
        logic [DRV_W-1:0] drive;
    } drive_out_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic signed [31:0]      encoder_count = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [PWM_W-1:0]        pwm_duty;
    logic [DIR_W-1:0]        direction;
    logic signed [REF_W-1:0] reference_counts;
    logic signed [VEL_W-1:0] velocity_counts;
    logic signed [DRV_W-1:0] ideal_drive;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    cfg_t              model_cfg = CFG_AT_RESET;
    logic [TICK_W-1:0] seq_ticks = '0;
    logic [2:0]        seq_phase = PHASE_FIRST;
    longint            last_count = 0;
    bit                dither_up = 1'b0;

    logic signed [31:0] count_feed[$];
    drive_out_t         predicted_outputs[$];
    drive_out_t         seen_out;
    drive_out_t         due_out;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 fault_count = 0;
    int                 quiet_cycles = 0;

    p_position_loop_deadzone_dither_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .encoder_count    (encoder_count),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pwm_duty         (pwm_duty),
        .direction        (direction),
        .reference_counts (reference_counts),
        .velocity_counts  (velocity_counts),
        .ideal_drive      (ideal_drive),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint clamp_pwm(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic void predict_drive(logic signed [31:0] raw);
        longint          cnt;
        longint          lim;
        longint          setpoint;
        longint          diff;
        longint          vel;
        longint          err;
        longint          drive;
        longint          fin;
        longint unsigned mag;
        drive_out_t      o;
        cnt = raw;
        lim = longint'(model_cfg.max_pwm);
        seq_ticks = seq_ticks + 1'b1;
        if (seq_ticks >= model_cfg.step_ticks)
        begin
            seq_ticks = '0;
            seq_phase = (seq_phase >= PHASE_LAST) ? PHASE_FIRST : seq_phase + 3'd1;
        end
        case (seq_phase)
            PHASE_POS: setpoint = longint'(model_cfg.step_counts);
            PHASE_NEG: setpoint = -longint'(model_cfg.step_counts);
            default:   setpoint = 0;
        endcase
        diff = cnt - last_count;
        if (diff > 32767)
            vel = 32767;
        else if (diff < -32767)
            vel = -32768;
        else
            vel = diff;
        last_count = cnt;
        err = setpoint - cnt;
        mag = (err < 0) ? -err : err;
        if (mag < model_cfg.deadband_counts)
            drive = 0;
        else
        begin
            mag = (mag * model_cfg.gain_q16) >> 16;
            if (mag > model_cfg.max_pwm)
                mag = 64'(model_cfg.max_pwm);
            drive = (err < 0) ? -longint'(mag) : longint'(mag);
        end
        fin = drive;
        if (drive > 0)
            fin = clamp_pwm(drive + longint'(model_cfg.deadzone_fwd), lim);
        else if (drive < 0)
            fin = clamp_pwm(drive - longint'(model_cfg.deadzone_bwd), lim);
        // dither flag only moves on nonzero drive
        if (drive != 0)
        begin
            dither_up = !dither_up;
            fin = dither_up ? fin + longint'(model_cfg.dither_amplitude)
                            : fin - longint'(model_cfg.dither_amplitude);
            fin = clamp_pwm(fin, lim);
        end
        o.duty     = PWM_W'((fin < 0) ? -fin : fin);
        o.dir      = (fin > 0) ? DIR_FWD : ((fin < 0) ? DIR_BWD : DIR_STOP);
        o.setpoint = REF_W'(setpoint);
        o.velocity = VEL_W'(vel);
        o.drive    = DRV_W'(drive);
        predicted_outputs.push_back(o);
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_GAIN_Q16:        model_cfg.gain_q16 = d;
            REG_DEADZONE_FWD:    model_cfg.deadzone_fwd = d[PWM_W-1:0];
            REG_DEADZONE_BWD:    model_cfg.deadzone_bwd = d[PWM_W-1:0];
            REG_DITHER_AMPL:     model_cfg.dither_amplitude = d[PWM_W-1:0];
            REG_MAX_PWM:         model_cfg.max_pwm = d[PWM_W-1:0];
            REG_STEP_TICKS:      model_cfg.step_ticks = d[TICK_W-1:0];
            REG_STEP_COUNTS:     model_cfg.step_counts = d[STEP_W-1:0];
            REG_DEADBAND_COUNTS: model_cfg.deadband_counts = d[STEP_W-1:0];
            default: ;
        endcase
    endfunction

    // mostly counts near one of the three reference levels, some extremes and raw noise
    function automatic logic signed [31:0] pick_count();
        int unsigned kind;
        longint      base;
        longint      span;
        kind = $urandom_range(99);
        if (kind < 12)
            return $urandom();
        if (kind < 18)
        begin
            case ($urandom_range(3))
                0:       return 32'h7FFFFFFF;
                1:       return 32'h80000000;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        case ($urandom_range(2))
            0:       base = 0;
            1:       base = longint'(model_cfg.step_counts);
            default: base = -longint'(model_cfg.step_counts);
        endcase
        case ($urandom_range(3))
            0:       span = longint'(model_cfg.deadband_counts) + 2;
            1:       span = 64;
            2:       span = 4096;
            default: span = 70000;
        endcase
        return 32'(base + longint'($urandom_range(32'(2 * span))) - span);
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, d);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(cfg_t c, bit scramble_high);
        logic [CFG_DATA_W-1:0] hi;
        hi = '0;
        if (scramble_high)
            hi = CFG_DATA_W'($urandom());
        write_reg(REG_GAIN_Q16, c.gain_q16);
        write_reg(REG_DEADZONE_FWD, {hi[CFG_DATA_W-1:PWM_W], c.deadzone_fwd});
        write_reg(REG_DEADZONE_BWD, {hi[CFG_DATA_W-1:PWM_W], c.deadzone_bwd});
        write_reg(REG_DITHER_AMPL, {hi[CFG_DATA_W-1:PWM_W], c.dither_amplitude});
        write_reg(REG_MAX_PWM, {hi[CFG_DATA_W-1:PWM_W], c.max_pwm});
        write_reg(REG_STEP_TICKS, {hi[CFG_DATA_W-1:TICK_W], c.step_ticks});
        write_reg(REG_STEP_COUNTS, {hi[CFG_DATA_W-1:STEP_W], c.step_counts});
        write_reg(REG_DEADBAND_COUNTS, {hi[CFG_DATA_W-1:STEP_W], c.deadband_counts});
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (count_feed.size() != 0 || in_valid || predicted_outputs.size() != 0);
    endtask

    task automatic run_counts(int n, int send_pct, int recv_pct);
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n) count_feed.push_back(pick_count());
        wait_idle();
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            encoder_count <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_drive(encoder_count);
            if (!in_valid || in_ready)
            begin
                if (count_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid      <= 1'b1;
                    encoder_count <= count_feed.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                seen_out = {pwm_duty, direction, reference_counts, velocity_counts, ideal_drive};
                if (predicted_outputs.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected response at %0t ns", $time);
                end
                else
                begin
                    due_out = predicted_outputs.pop_front();
                    if (seen_out.duty !== due_out.duty || seen_out.dir !== due_out.dir
                        || seen_out.setpoint !== due_out.setpoint
                        || seen_out.velocity !== due_out.velocity
                        || seen_out.drive !== due_out.drive)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                        begin
                            $display("mismatch at %0t ns: exp duty %0d dir %0d ref %0d vel %0d drv %0d",
                                     $time, due_out.duty, due_out.dir, $signed(due_out.setpoint),
                                     $signed(due_out.velocity), $signed(due_out.drive));
                            $display("    got duty %0d dir %0d ref %0d vel %0d drv %0d",
                                     seen_out.duty, seen_out.dir, $signed(seen_out.setpoint),
                                     $signed(seen_out.velocity), $signed(seen_out.drive));
                        end
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        cfg_t phase_cfg;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // default registers straight out of reset
        @(negedge clk);
        foreach (EDGE_COUNTS[i])
            count_feed.push_back(EDGE_COUNTS[i]);
        wait_idle();

        // phase advance on every tick, all drive stages pinned to zero
        write_reg(REG_STEP_TICKS, '0);
        write_reg(REG_MAX_PWM, '0);
        run_counts(6, 0, 0);

        // top-of-range registers, upper data bits must be dropped
        write_reg(REG_MAX_PWM, '1);
        write_reg(REG_GAIN_Q16, '1);
        write_reg(REG_DEADZONE_FWD, '1);
        write_reg(REG_DEADZONE_BWD, '1);
        write_reg(REG_DITHER_AMPL, '1);
        write_reg(REG_STEP_TICKS, 24'd2);
        write_reg(REG_UNUSED, 24'd1);
        run_counts(5, 0, 0);

        for (int p = 0; p < 8; p++)
        begin
            phase_cfg.gain_q16         = GAIN_W'($urandom_range(1 << 20));
            phase_cfg.deadzone_fwd     = PWM_W'($urandom_range(3000));
            phase_cfg.deadzone_bwd     = PWM_W'($urandom_range(3000));
            phase_cfg.dither_amplitude = PWM_W'($urandom_range(1500));
            phase_cfg.max_pwm          = PWM_W'($urandom_range(32767, 1));
            phase_cfg.step_ticks       = TICK_W'((p == 4) ? $urandom_range(4, 1)
                                                          : $urandom_range(60, 1));
            phase_cfg.step_counts      = STEP_W'($urandom_range(5000));
            phase_cfg.deadband_counts  = STEP_W'($urandom_range(16));
            case (p)
                0: phase_cfg = CFG_AT_RESET;
                2: phase_cfg = '{'1, '1, '1, '1, '1, '1, '1, '1};
                3: phase_cfg = '{24'd0, 15'd0, 15'd0, 15'd0, 15'd1, 16'd1, 16'd0, 16'd0};
                5: phase_cfg = ($bits(cfg_t))'({$urandom(), $urandom(), $urandom(),
                                                $urandom(), $urandom()});
                6:
                begin
                    // dither larger than the drive range flips direction
                    phase_cfg.step_ticks       = '0;
                    phase_cfg.max_pwm          = PWM_W'($urandom_range(200, 1));
                    phase_cfg.dither_amplitude = PWM_W'($urandom_range(400));
                end
                default: ;
            endcase
            program_regs(phase_cfg, p >= 4);
            // sender holds off mid-phase until every response is back
            case (p % 4)
                0:
                begin
                    run_counts(ITEMS_PER_PHASE / 2, 0, 0);
                    run_counts(ITEMS_PER_PHASE / 2, 0, 0);
                end
                1:
                begin
                    run_counts(ITEMS_PER_PHASE / 2, 75, 0);
                    run_counts(ITEMS_PER_PHASE / 2, 75, 0);
                end
                2:
                begin
                    run_counts(ITEMS_PER_PHASE / 2, 0, 75);
                    run_counts(ITEMS_PER_PHASE / 2, 0, 75);
                end
                default:
                begin
                    run_counts(ITEMS_PER_PHASE / 2, 29, 29);
                    run_counts(ITEMS_PER_PHASE / 2, 29, 29);
                end
            endcase
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0 && predicted_outputs.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
